// ===== hdl/ptsp_pkg.sv =====
// Shared types, constants and the bit-plane gather function for the
// planar tile and sprite packer. No dependencies.
package ptsp_pkg;

   localparam logic [1:0] LAYOUT_8X8       = 2'd0;
   localparam logic [1:0] LAYOUT_16_TILE   = 2'd1;
   localparam logic [1:0] LAYOUT_16_SPRITE = 2'd2;
   localparam logic [1:0] LAYOUT_INVALID   = 2'd3;

   localparam logic FORMAT_CHUNKY = 1'b0;
   localparam logic FORMAT_PACKED = 1'b1;

   localparam logic [1:0] REG_LAYOUT        = 2'd0;
   localparam logic [1:0] REG_SOURCE_FORMAT = 2'd1;

   localparam int PLANES  = 4;
   localparam int SLOTS   = 2 * PLANES;
   localparam int WORDS   = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [3:0] LAST_WORD_8X8  = 4'd3;
   localparam logic [3:0] LAST_WORD_16   = 4'd15;
   localparam logic [3:0] LAST_ROW_8X8   = 4'd7;
   localparam logic [3:0] LAST_ROW_16    = 4'd15;

   // One classified pixel row: up to eight plane bytes with their byte
   // positions in the 128-byte tile buffer, plus tile control flags.
   typedef struct packed {
      logic [SLOTS-1:0][7:0] data;
      logic [SLOTS-1:0][6:0] byte_idx;
      logic [SLOTS-1:0]      wr_en;
      logic                  clear;
      logic                  done;
      logic                  short_tile;
      logic                  err;
   } ptsp_row_type;

   // Gathers bit p of each of eight pixels; bit j comes from the pixel
   // j places from the right edge.
   function automatic logic [7:0] plane_byte(input logic [63:0] px, input int p,
                                             input logic packed_src);
      logic [7:0] r;
      r = '0;
      for (int j = 0; j < 8; j++) begin
         r[j] = packed_src ? px[4*j + p] : px[8*j + p];
      end
      return r;
   endfunction

endpackage

// ===== hdl/ptsp_channels.sv =====
// Handshake channel interfaces of the planar tile and sprite packer:
// pixel row requests, packed word responses and register writes. No dependencies.
interface ptsp_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] left_pixels;
   logic [63:0] right_pixels;
   modport source (output valid, output left_pixels, output right_pixels, input ready);
   modport sink   (input valid, input left_pixels, input right_pixels, output ready);
endinterface

interface ptsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_word;
   logic [3:0]  word_index;
   logic        last;
   logic        format_error;
   modport source (output valid, output out_word, output word_index, output last,
                   output format_error, input ready);
   modport sink   (input valid, input out_word, input word_index, input last,
                   input format_error, output ready);
endinterface

interface ptsp_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/ptsp_front.sv =====
// Front end: configuration registers, row counter and per-row classification
// into buffer byte writes. Depends on ptsp_pkg and ptsp_channels.
module ptsp_front (
   input  logic                  clock,
   input  logic                  reset,
   ptsp_req_if.sink              req_chan,
   ptsp_csr_if.sink              csr_chan,
   input  logic                  queue_full,
   output logic                  push,
   output ptsp_pkg::ptsp_row_type entry
);
   import ptsp_pkg::*;

   logic [1:0] layout_ff, layout_in;
   logic       format_ff, format_in;
   logic [3:0] row_count_ff, row_count_in;

   logic [PLANES-1:0][7:0] lplane, rplane;
   logic [6:0] base;
   logic       err;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !queue_full;
   assign push = req_chan.valid && !queue_full;

   always_comb begin
      layout_in = layout_ff;
      format_in = format_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_LAYOUT:        layout_in = csr_chan.data;
            REG_SOURCE_FORMAT: format_in = csr_chan.data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int p = 0; p < PLANES; p++) begin
         lplane[p] = plane_byte(req_chan.left_pixels, p, format_ff);
         rplane[p] = plane_byte(req_chan.right_pixels, p, format_ff);
      end
   end

   always_comb begin
      err = (layout_ff == LAYOUT_INVALID) ||
            (layout_ff == LAYOUT_16_TILE && format_ff == FORMAT_PACKED);
      entry = '0;
      base = '0;
      case (layout_ff)
         LAYOUT_8X8: begin
            base = {3'b000, row_count_ff[2:0], 1'b0};
            for (int p = 0; p < PLANES; p++) begin
               entry.byte_idx[p] = base + 7'(p % 2) + 7'(16 * (p / 2));
               entry.data[p]     = lplane[p];
               entry.wr_en[p]    = 1'b1;
            end
         end
         LAYOUT_16_TILE: begin
            // Rows 8 to 15 fall in the bottom blocks, 64 bytes further on.
            base = row_count_ff[3] ? {2'b00, row_count_ff, 1'b0} + 7'd48
                                   : {2'b00, row_count_ff, 1'b0};
            for (int p = 0; p < PLANES; p++) begin
               entry.byte_idx[p]          = base + 7'(p % 2) + 7'(16 * (p / 2));
               entry.data[p]              = lplane[p];
               entry.wr_en[p]             = 1'b1;
               entry.byte_idx[p + PLANES] = base + 7'd32 + 7'(p % 2) + 7'(16 * (p / 2));
               entry.data[p + PLANES]     = rplane[p];
               entry.wr_en[p + PLANES]    = 1'b1;
            end
         end
         LAYOUT_16_SPRITE: begin
            base = {2'b00, row_count_ff, 1'b0};
            for (int p = 0; p < PLANES; p++) begin
               entry.byte_idx[p]          = base + 7'(32 * p);
               entry.data[p]              = rplane[p];
               entry.wr_en[p]             = 1'b1;
               entry.byte_idx[p + PLANES] = base + 7'd1 + 7'(32 * p);
               entry.data[p + PLANES]     = lplane[p];
               entry.wr_en[p + PLANES]    = 1'b1;
            end
         end
         default: ;
      endcase
      if (err) begin
         entry.wr_en = '0;
      end
      entry.err        = err;
      entry.clear      = (row_count_ff == 4'd0);
      entry.short_tile = (layout_ff == LAYOUT_8X8);
      entry.done       = (layout_ff == LAYOUT_8X8) ? (row_count_ff >= LAST_ROW_8X8)
                                                   : (row_count_ff == LAST_ROW_16);
   end

   always_comb begin
      row_count_in = row_count_ff;
      if (push) begin
         row_count_in = entry.done ? 4'd0 : row_count_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff    <= LAYOUT_8X8;
         format_ff    <= FORMAT_CHUNKY;
         row_count_ff <= '0;
      end else begin
         layout_ff    <= layout_in;
         format_ff    <= format_in;
         row_count_ff <= row_count_in;
      end
   end

   a_done_restarts: assert property (@(posedge clock) disable iff (reset)
      push && entry.done |=> row_count_ff == 4'd0)
      else $error("row counter did not restart after the last row of a tile");

   a_row_advances: assert property (@(posedge clock) disable iff (reset)
      push && !entry.done |=> row_count_ff == $past(row_count_ff) + 4'd1)
      else $error("row counter did not advance on an accepted row");

   a_err_no_write: assert property (@(posedge clock) disable iff (reset)
      entry.err |-> entry.wr_en == '0)
      else $error("unsupported format combination still writes the buffer");

endmodule

// ===== hdl/ptsp_queue.sv =====
// Short FIFO of classified rows between the front and back ends.
// Depends on ptsp_pkg.
module ptsp_queue #(
   parameter int DEPTH = ptsp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ptsp_pkg::ptsp_row_type push_entry,
   input  logic                  pop,
   output ptsp_pkg::ptsp_row_type head,
   output logic                  full,
   output logic                  empty
);
   import ptsp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ptsp_row_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("row queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("row queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("row queue occupancy out of range");

endmodule

// ===== hdl/ptsp_back.sv =====
// Back end: tile buffer, row writes and the word drain into the response
// output register. Depends on ptsp_pkg and ptsp_channels.
module ptsp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  queue_empty,
   input  ptsp_pkg::ptsp_row_type head,
   output logic                  pop,
   ptsp_rsp_if.source            rsp_chan
);
   import ptsp_pkg::*;

   typedef enum logic {
      BK_ACCEPT,
      BK_DRAIN
   } back_state_type;

   back_state_type state_ff;
   logic [3:0]  word_ff;
   logic [3:0]  last_word_ff;
   logic        err_ff;

   logic        rsp_valid_ff;
   logic [63:0] rsp_word_ff;
   logic [3:0]  rsp_index_ff;
   logic        rsp_last_ff;
   logic        rsp_error_ff;

   logic [7:0][7:0] tile_store_ff [WORDS];
   logic [8*WORDS-1:0] row_hit;

   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop = (state_ff == BK_ACCEPT) && !queue_empty;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_word     = rsp_word_ff;
   assign rsp_chan.word_index   = rsp_index_ff;
   assign rsp_chan.last         = rsp_last_ff;
   assign rsp_chan.format_error = rsp_error_ff;

   // Marks the buffer bytes that the row at the queue head writes.
   always_comb begin
      row_hit = '0;
      for (int s = 0; s < SLOTS; s++) begin
         if (head.wr_en[s]) begin
            row_hit[head.byte_idx[s]] = 1'b1;
         end
      end
   end

   // The first row of a tile zeroes every byte that it does not write itself.
   always_ff @(posedge clock) begin
      if (pop) begin
         for (int w = 0; w < WORDS; w++) begin
            for (int b = 0; b < 8; b++) begin
               if (head.clear && !row_hit[8*w + b]) begin
                  tile_store_ff[w][b] <= '0;
               end
            end
         end
         for (int s = 0; s < SLOTS; s++) begin
            if (head.wr_en[s]) begin
               tile_store_ff[head.byte_idx[s][6:3]][head.byte_idx[s][2:0]] <= head.data[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_ACCEPT;
         word_ff      <= '0;
         last_word_ff <= LAST_WORD_8X8;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            BK_ACCEPT: begin
               if (rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (pop && head.done) begin
                  state_ff     <= BK_DRAIN;
                  word_ff      <= '0;
                  last_word_ff <= head.short_tile ? LAST_WORD_8X8 : LAST_WORD_16;
                  err_ff       <= head.err;
               end
            end
            BK_DRAIN: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_word_ff  <= err_ff ? 64'd0 : tile_store_ff[word_ff];
                  rsp_index_ff <= word_ff;
                  rsp_last_ff  <= (word_ff == last_word_ff);
                  rsp_error_ff <= err_ff;
                  if (word_ff == last_word_ff) begin
                     state_ff <= BK_ACCEPT;
                  end else begin
                     word_ff <= word_ff + 4'd1;
                  end
               end
            end
            default: state_ff <= BK_ACCEPT;
         endcase
      end
   end

   a_drain_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_DRAIN |-> word_ff <= last_word_ff)
      else $error("drain counter ran past the last word");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_error_ff |-> rsp_word_ff == 64'd0)
      else $error("error word carries nonzero data");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |->
         (rsp_index_ff == LAST_WORD_8X8 || rsp_index_ff == LAST_WORD_16))
      else $error("last flag on a word that cannot end a tile");

   a_no_pop_in_drain: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_DRAIN |-> !pop)
      else $error("row taken from the queue while the buffer drains");

endmodule

// ===== hdl/planar_tile_sprite_packer.sv =====
// Top level of the planar tile and sprite packer: front end, row queue and
// back end. Depends on ptsp_pkg, ptsp_channels, ptsp_front, ptsp_queue, ptsp_back.
//
// Usage:
// Each req_chan transaction carries one row of 4-bit pixels (left and right
// halves, chunky bytes or packed nibbles). The front end turns the row into
// bit-plane bytes and their positions in the 128-byte tile buffer and queues
// them. The back end writes one queued row into the buffer per cycle while it
// is not draining a tile. When a row ends a tile (8 rows for the 8x8 layout,
// 16 otherwise) the back end sends the buffer on rsp_chan as 4 or 16 64-bit
// words, one per cycle while the receiver is ready, with word_index counting
// from 0 and last set on the final word. Packed pixels with the 16x16 tile
// layout, or layout code 3, give zero words with format_error set.
// A row is registered in the queue before the back end writes it into the
// buffer, and each word is registered in the response output register.
// req_chan takes one row per cycle while the queue has room. The back end
// takes no rows from the queue while it drains the single tile buffer, so
// rows of a new tile wait in the queue during the drain.
// csr_chan is always ready; register index 0 is layout, 1 is source format.
// Write them only while no tile is in flight in the pipeline.
// Reset clears the row counter, queue and registers (layout 0, chunky).
// When the receiver stalls, the output register holds its word, the drain
// pauses, the queue fills and req_chan.ready falls.
module planar_tile_sprite_packer #(
   parameter int QUEUE_DEPTH = ptsp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   ptsp_req_if.sink   req_chan,
   ptsp_rsp_if.source rsp_chan,
   ptsp_csr_if.sink   csr_chan
);
   import ptsp_pkg::*;

   ptsp_row_type push_entry;
   ptsp_row_type head;
   logic         push;
   logic         pop;
   logic         queue_full;
   logic         queue_empty;

   // Classification and configuration.
   ptsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .queue_full (queue_full),
      .push       (push),
      .entry      (push_entry)
   );

   // Decouples row acceptance from the buffer drain.
   ptsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   // Buffer writes and word output.
   ptsp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule
